// ===== rtl/lss_pkg.sv =====
// shared constants, codes and types for the line substring search block
// no dependencies; every other file imports this package
package lss_pkg;

   localparam int MAX_NEEDLE    = 32;
   localparam int NEEDLE_IDX_W  = $clog2(MAX_NEEDLE);
   localparam int LEN_W         = 6;
   localparam int OFFSET_W      = 15;
   localparam int BYTE_W        = 8;
   localparam int STATUS_W      = 2;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_IDX_W     = 3;
   localparam int NEEDLE_REGS   = 4;
   localparam int BYTES_PER_REG = CSR_DATA_W / BYTE_W;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

   localparam logic [STATUS_W-1:0] END_NOT_LAST     = 2'd0;
   localparam logic [STATUS_W-1:0] END_SOME_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] END_NONE_FOUND   = 2'd1;
   localparam logic [STATUS_W-1:0] END_EMPTY_NEEDLE = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NEEDLE_LENGTH  = 3'd0,
      REG_NEEDLE_BYTES_0 = 3'd1,
      REG_NEEDLE_BYTES_1 = 3'd2,
      REG_NEEDLE_BYTES_2 = 3'd3,
      REG_NEEDLE_BYTES_3 = 3'd4
   } reg_index_type;

   // needle as seen by the compare: pattern[j] lines up with window byte j
   typedef struct packed {
      logic                                 active;
      logic [LEN_W-1:0]                     length;
      logic [MAX_NEEDLE-1:0]                mask;
      logic [MAX_NEEDLE-1:0][BYTE_W-1:0]    pattern;
   } lss_needle_type;

endpackage

// ===== rtl/lss_if.sv =====
// item channel interfaces for the text input and the line result output
// depends on lss_pkg
interface lss_req_if;
   import lss_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              last_byte;
   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface lss_rsp_if;
   import lss_pkg::*;
   logic                valid;
   logic                ready;
   logic                line_hit;
   logic [OFFSET_W-1:0] line_number;
   logic [OFFSET_W-1:0] line_start;
   logic [OFFSET_W-1:0] line_end;
   logic                end_of_text;
   logic [STATUS_W-1:0] end_status;
   modport source (output valid, output line_hit, output line_number, output line_start,
                   output line_end, output end_of_text, output end_status, input ready);
   modport sink   (input valid, input line_hit, input line_number, input line_start,
                   input line_end, input end_of_text, input end_status, output ready);
endinterface

// ===== rtl/lss_csr.sv =====
// configuration registers on the apb-style port and the aligned needle image
// depends on lss_pkg
module lss_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lss_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lss_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output lss_pkg::lss_needle_type        needle
);
   import lss_pkg::*;

   logic [LEN_W-1:0]      length_ff;
   logic [CSR_DATA_W-1:0] bytes_ff [NEEDLE_REGS];
   lss_needle_type        needle_ff;
   lss_needle_type        needle_in;
   reg_index_type         index;
   logic                  wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign needle = needle_ff;

   always_comb begin
      case (index)
         REG_NEEDLE_LENGTH:  prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, length_ff};
         REG_NEEDLE_BYTES_0: prdata = bytes_ff[0];
         REG_NEEDLE_BYTES_1: prdata = bytes_ff[1];
         REG_NEEDLE_BYTES_2: prdata = bytes_ff[2];
         REG_NEEDLE_BYTES_3: prdata = bytes_ff[3];
         default:            prdata = '0;
      endcase
   end

   // reverse the needle so the newest window byte meets the last needle byte
   always_comb begin
      logic [LEN_W-1:0]        pos;
      logic [NEEDLE_IDX_W-1:0] idx;
      needle_in.length = length_ff;
      needle_in.active = (length_ff != '0) && (length_ff <= LEN_W'(MAX_NEEDLE));
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         pos = LEN_W'(j);
         idx = NEEDLE_IDX_W'(length_ff - pos - LEN_W'(1));
         needle_in.mask[j]    = pos < length_ff;
         needle_in.pattern[j] = bytes_ff[idx[NEEDLE_IDX_W-1:3]][{idx[2:0], 3'b000} +: BYTE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         for (int r = 0; r < NEEDLE_REGS; r++) begin
            bytes_ff[r] <= '0;
         end
         needle_ff <= '0;
      end else begin
         needle_ff <= needle_in;
         if (wr_en) begin
            case (index)
               REG_NEEDLE_LENGTH:  length_ff   <= pwdata[LEN_W-1:0];
               REG_NEEDLE_BYTES_0: bytes_ff[0] <= pwdata;
               REG_NEEDLE_BYTES_1: bytes_ff[1] <= pwdata;
               REG_NEEDLE_BYTES_2: bytes_ff[2] <= pwdata;
               REG_NEEDLE_BYTES_3: bytes_ff[3] <= pwdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== rtl/lss_match.sv =====
// parallel compare of the shifted line window against the aligned needle
// depends on lss_pkg
module lss_match (
   input  logic [lss_pkg::MAX_NEEDLE-1:0][lss_pkg::BYTE_W-1:0] window,
   input  logic [lss_pkg::LEN_W-1:0]                           chars,
   input  lss_pkg::lss_needle_type                             needle,
   output logic                                                hit
);
   import lss_pkg::*;

   logic [MAX_NEEDLE-1:0] pos_ok;

   always_comb begin
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         pos_ok[j] = !needle.mask[j] || (window[j] == needle.pattern[j]);
      end
   end

   assign hit = needle.active && (chars >= needle.length) && (&pos_ok);

endmodule

// ===== rtl/lss_scan.sv =====
// input register, line window and counters, result register
// depends on lss_pkg, lss_if and lss_match
module lss_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  lss_pkg::lss_needle_type needle,
   lss_req_if.sink                 req_ch,
   lss_rsp_if.source               rsp_ch
);
   import lss_pkg::*;

   logic                                  s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]                     s1_byte_ff;
   logic                                  s1_last_ff;
   logic [MAX_NEEDLE-1:0][BYTE_W-1:0]     win_ff, win_in;
   logic [LEN_W-1:0]                      chars_ff, chars_in;
   logic                                  matched_ff, matched_in;
   logic [OFFSET_W-1:0]                   line_ff, line_in;
   logic [OFFSET_W-1:0]                   begin_ff, begin_in;
   logic [OFFSET_W-1:0]                   offset_ff, offset_in;
   logic                                  found_ff, found_in;
   logic                                  out_valid_ff, out_valid_in;
   logic                                  out_hit_ff;
   logic [OFFSET_W-1:0]                   out_number_ff, out_start_ff, out_end_ff;
   logic                                  out_eot_ff;
   logic [STATUS_W-1:0]                   out_status_ff, status;

   logic                                  accept, is_nl, ends, out_free, advance, hit;
   logic [MAX_NEEDLE-1:0][BYTE_W-1:0]     shifted;
   logic [LEN_W-1:0]                      chars_shift;
   logic [OFFSET_W-1:0]                   next_off;
   logic                                  line_hit, found_next;

   assign is_nl    = s1_byte_ff == NEWLINE_BYTE;
   assign ends     = is_nl || s1_last_ff;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign advance  = s1_valid_ff && (!ends || out_free);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept   = req_ch.valid && req_ch.ready;

   assign shifted     = {win_ff[MAX_NEEDLE-2:0], s1_byte_ff};
   assign chars_shift = (chars_ff < LEN_W'(MAX_NEEDLE)) ? chars_ff + LEN_W'(1) : chars_ff;
   assign next_off    = offset_ff + OFFSET_W'(1);

   lss_match u_match (
      .window (shifted),
      .chars  (chars_shift),
      .needle (needle),
      .hit    (hit)
   );

   assign line_hit   = matched_ff || (!is_nl && hit);
   assign found_next = found_ff || line_hit;

   always_comb begin
      if (!s1_last_ff) begin
         status = END_NOT_LAST;
      end else if (needle.length == '0) begin
         status = END_EMPTY_NEEDLE;
      end else if (found_next) begin
         status = END_SOME_FOUND;
      end else begin
         status = END_NONE_FOUND;
      end
   end

   always_comb begin
      win_in    = win_ff;
      chars_in  = chars_ff;
      matched_in = matched_ff;
      line_in   = line_ff;
      begin_in  = begin_ff;
      offset_in = offset_ff;
      found_in  = found_ff;
      if (advance) begin
         if (!ends) begin
            win_in     = shifted;
            chars_in   = chars_shift;
            matched_in = line_hit;
            offset_in  = next_off;
         end else if (s1_last_ff) begin
            win_in     = '0;
            chars_in   = '0;
            matched_in = 1'b0;
            line_in    = OFFSET_W'(1);
            begin_in   = '0;
            offset_in  = '0;
            found_in   = 1'b0;
         end else begin
            win_in     = '0;
            chars_in   = '0;
            matched_in = 1'b0;
            line_in    = line_ff + OFFSET_W'(1);
            begin_in   = next_off;
            offset_in  = next_off;
            found_in   = found_next;
         end
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = (advance && ends) ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         win_ff       <= '0;
         chars_ff     <= '0;
         matched_ff   <= 1'b0;
         line_ff      <= OFFSET_W'(1);
         begin_ff     <= '0;
         offset_ff    <= '0;
         found_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         win_ff       <= win_in;
         chars_ff     <= chars_in;
         matched_ff   <= matched_in;
         line_ff      <= line_in;
         begin_ff     <= begin_in;
         offset_ff    <= offset_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_ch.text_byte;
         s1_last_ff <= req_ch.last_byte;
      end
      if (advance && ends) begin
         out_hit_ff    <= line_hit;
         out_number_ff <= line_ff;
         out_start_ff  <= begin_ff;
         out_end_ff    <= next_off;
         out_eot_ff    <= s1_last_ff;
         out_status_ff <= status;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.line_hit    = out_hit_ff;
   assign rsp_ch.line_number = out_number_ff;
   assign rsp_ch.line_start  = out_start_ff;
   assign rsp_ch.line_end    = out_end_ff;
   assign rsp_ch.end_of_text = out_eot_ff;
   assign rsp_ch.end_status  = out_status_ff;

endmodule

// ===== rtl/line_substring_search.sv =====
// top level of the per-line needle search: registers and the scan pipeline
// depends on lss_pkg, lss_if, lss_csr, lss_scan
//
//   channel   direction   handshake              payload
//   req_ch    in          valid/ready            text_byte, last_byte
//   rsp_ch    out         valid/ready            line_hit .. end_status, one item per line end
//   csr       in/out      psel/penable/pready    paddr, pwdata, prdata (64 bit, reg i at 8*i)
//
// one text item per cycle unless a closing item waits on a full result register; a closing
// item goes into the input register, its result into the result register, and the 32-byte
// window compare sits between the two; reset clears window, counters, offsets and all needle
// registers and sets the line number to 1; with the result register full, one more item is
// taken into the input register; items that close no line keep flowing past a stalled result
module line_substring_search (
   input  logic                           clock,
   input  logic                           reset,
   lss_req_if.sink                        req_ch,
   lss_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lss_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lss_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import lss_pkg::*;

   lss_needle_type needle;

   lss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .needle  (needle)
   );

   lss_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .needle (needle),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTH
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.end_of_text |-> rsp_ch.end_status == END_NOT_LAST)
      else $error("end status set on a result that is not the last");

   a_hit_means_found: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.end_of_text && rsp_ch.line_hit
      |-> rsp_ch.end_status == END_SOME_FOUND)
      else $error("matching last line without found status");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("input stalled with no result pending");

   a_empty_needle_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.end_of_text && rsp_ch.end_status == END_EMPTY_NEEDLE
      |-> !rsp_ch.line_hit)
      else $error("hit reported with empty needle");
`endif

endmodule
